// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk_i while reset is released.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks a property at every rising edge of clk_i, also during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/hsvrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB package
// Types, constants and arithmetic helpers shared by the converter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned HueW    = 16;
  localparam int unsigned DegW    = 9;
  localparam int unsigned ProdW   = 2 * ChanW;

  localparam logic [DegW-1:0]  DegFull   = 9'd360;
  localparam logic [DegW-1:0]  DegRegion = 9'd60;
  localparam logic [ChanW-1:0] LevelMax  = 8'd255;

  // Reciprocal of 360 scaled by 2^24, rounded up; exact for every 16-bit hue.
  localparam logic [HueW-1:0]  HueRecip  = 16'd46604;
  localparam int unsigned      RecipShift = 24;

  // 255 / 60 equals 17 / 4, so the region position scales exactly.
  localparam logic [4:0]       FracMul   = 5'd17;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_e;

  typedef struct packed {
    sector_e           sector;
    logic              gray;
    logic [ChanW-1:0]  val;
    logic [ChanW-1:0]  lo;
    logic [ProdW-1:0]  fall_prod;
    logic [ProdW-1:0]  rise_prod;
  } mix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  // Truncating division by 255, exact for every product of two 8-bit values.
  function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] x);
    logic [ProdW:0] s;
    s = {1'b0, x} + {{(ProdW-ChanW+1){1'b0}}, x[ProdW-1:ChanW]} + 17'd1;
    return s[ProdW-1:ChanW];
  endfunction

endpackage

`default_nettype wire

// ===== sv/hsvrgb_mix.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB channel mix
// Finishes the falling and rising terms and routes the terms to the channels.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_mix (
  input  hsvrgb_pkg::mix_in_t mix_i,
  output hsvrgb_pkg::rgb_t    rgb_o
);
  import hsvrgb_pkg::*;

  logic [ChanW-1:0] fall;
  logic [ChanW-1:0] rise;
  logic [ChanW-1:0] v;
  logic [ChanW-1:0] p;

  assign fall = div255(mix_i.fall_prod);
  assign rise = div255(mix_i.rise_prod);
  assign v    = mix_i.val;
  assign p    = mix_i.lo;

  always_comb begin
    if (mix_i.gray) begin
      rgb_o = '{red: v, green: v, blue: v};
    end else begin
      unique case (mix_i.sector)
        SEC_RED_YELLOW:   rgb_o = '{red: v,    green: rise, blue: p};
        SEC_YELLOW_GREEN: rgb_o = '{red: fall, green: v,    blue: p};
        SEC_GREEN_CYAN:   rgb_o = '{red: p,    green: v,    blue: rise};
        SEC_CYAN_BLUE:    rgb_o = '{red: p,    green: fall, blue: v};
        SEC_BLUE_MAGENTA: rgb_o = '{red: rise, green: p,    blue: v};
        default:          rgb_o = '{red: v,    green: p,    blue: fall};
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Integer conversion of one HSV pixel into one 8-bit RGB pixel.
//
// The converter takes one pixel transaction per clock while stall_o is low
// and returns one RGB transaction for each, in order. The six register
// stages are: hue quotient by a reciprocal multiply, hue remainder and low
// term product, region and position, the two saturation products
// and the low term division, the two brightness
// products, and the output register where the terms are routed. Every stage
// holds its own valid bit and moves whenever the stage after it has room, so
// a stall on the output fills empty stages first and drops nothing. A hue of
// any 16-bit value is reduced modulo 360; a saturation of zero gives a gray
// pixel equal to the brightness. There is no configuration and no state
// beyond the pipeline itself.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hsv_to_rgb_converter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  logic [hsvrgb_pkg::HueW-1:0]         hue_i,
  input  logic [hsvrgb_pkg::ChanW-1:0]        saturation_i,
  input  logic [hsvrgb_pkg::ChanW-1:0]        brightness_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output logic [hsvrgb_pkg::ChanW-1:0]        red_o,
  output logic [hsvrgb_pkg::ChanW-1:0]        green_o,
  output logic [hsvrgb_pkg::ChanW-1:0]        blue_o
);
  import hsvrgb_pkg::*;

  // Valid bits of the six stages; stage six is the output register.
  logic [6:1] vld_q;
  logic [6:1] rdy;

  // A stage takes new data when it is empty or when its content moves on.
  always_comb begin
    rdy[6] = !vld_q[6] || !stall_i;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign stall_o = !rdy[1];
  assign valid_o = vld_q[6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[1]) vld_q[1] <= valid_i;
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Stage one: quotient of the hue by 360 through the scaled reciprocal.
  logic [2*HueW-1:0] recip_prod;
  logic [ChanW-1:0]  s1_quot_d, s1_quot_q;
  logic [HueW-1:0]   s1_hue_q;
  logic [ChanW-1:0]  s1_sat_q, s1_val_q;

  assign recip_prod = hue_i * HueRecip;
  assign s1_quot_d  = recip_prod[RecipShift +: ChanW];

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s1_quot_q <= s1_quot_d;
      s1_hue_q  <= hue_i;
      s1_sat_q  <= saturation_i;
      s1_val_q  <= brightness_i;
    end
  end

  // Stage two: remainder of the hue, and the product behind the low term.
  logic [HueW:0]     quot_deg;
  logic [HueW:0]     deg_diff;
  logic [DegW-1:0]   s2_deg_d, s2_deg_q;
  logic [ProdW-1:0]  s2_lo_prod_d, s2_lo_prod_q;
  logic [ChanW-1:0]  s2_sat_q, s2_val_q;

  assign quot_deg     = s1_quot_q * DegFull;
  assign deg_diff     = {1'b0, s1_hue_q} - quot_deg;
  assign s2_deg_d     = deg_diff[DegW-1:0];
  assign s2_lo_prod_d = s1_val_q * (LevelMax - s1_sat_q);

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s2_deg_q     <= s2_deg_d;
      s2_lo_prod_q <= s2_lo_prod_d;
      s2_sat_q     <= s1_sat_q;
      s2_val_q     <= s1_val_q;
    end
  end

  // Stage three: 60-degree region and the position inside it, scaled to 0..250.
  sector_e          s3_sector_d, s3_sector_q;
  logic [DegW-1:0]  region_base;
  logic [DegW-1:0]  rem_deg;
  logic [9:0]       frac_scaled;
  logic [ChanW-1:0] s3_frac_d, s3_frac_q;
  logic [ProdW-1:0] s3_lo_prod_q;
  logic [ChanW-1:0] s3_sat_q, s3_val_q;

  always_comb begin
    if (s2_deg_q < DegRegion) begin
      s3_sector_d = SEC_RED_YELLOW;
      region_base = '0;
    end else if (s2_deg_q < 2 * DegRegion) begin
      s3_sector_d = SEC_YELLOW_GREEN;
      region_base = DegRegion;
    end else if (s2_deg_q < 3 * DegRegion) begin
      s3_sector_d = SEC_GREEN_CYAN;
      region_base = 9'(2 * DegRegion);
    end else if (s2_deg_q < 4 * DegRegion) begin
      s3_sector_d = SEC_CYAN_BLUE;
      region_base = 9'(3 * DegRegion);
    end else if (s2_deg_q < 5 * DegRegion) begin
      s3_sector_d = SEC_BLUE_MAGENTA;
      region_base = 9'(4 * DegRegion);
    end else begin
      s3_sector_d = SEC_MAGENTA_RED;
      region_base = 9'(5 * DegRegion);
    end
    rem_deg     = s2_deg_q - region_base;
    frac_scaled = rem_deg[5:0] * FracMul;
    s3_frac_d   = frac_scaled[9:2];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s3_sector_q  <= s3_sector_d;
      s3_frac_q    <= s3_frac_d;
      s3_lo_prod_q <= s2_lo_prod_q;
      s3_sat_q     <= s2_sat_q;
      s3_val_q     <= s2_val_q;
    end
  end

  // Stage four: saturation times position and its complement; low term done.
  logic [ProdW-1:0] s4_sf_q, s4_sfn_q;
  logic [ChanW-1:0] s4_lo_q;
  sector_e          s4_sector_q;
  logic [ChanW-1:0] s4_sat_q, s4_val_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      s4_sf_q     <= s3_sat_q * s3_frac_q;
      s4_sfn_q    <= s3_sat_q * (LevelMax - s3_frac_q);
      s4_lo_q     <= div255(s3_lo_prod_q);
      s4_sector_q <= s3_sector_q;
      s4_sat_q    <= s3_sat_q;
      s4_val_q    <= s3_val_q;
    end
  end

  // Stage five: brightness times the two attenuation levels.
  logic [ChanW-1:0] fall_lvl, rise_lvl;
  mix_in_t          s5_d, s5_q;

  assign fall_lvl = LevelMax - div255(s4_sf_q);
  assign rise_lvl = LevelMax - div255(s4_sfn_q);

  always_comb begin
    s5_d.sector    = s4_sector_q;
    s5_d.gray      = (s4_sat_q == '0);
    s5_d.val       = s4_val_q;
    s5_d.lo        = s4_lo_q;
    s5_d.fall_prod = s4_val_q * fall_lvl;
    s5_d.rise_prod = s4_val_q * rise_lvl;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      s5_q <= s5_d;
    end
  end

  // Stage six: final divisions and channel routing into the output register.
  rgb_t             rgb_d, rgb_q;
  logic [ChanW-1:0] s6_val_q;

  hsvrgb_mix u_mix (
    .mix_i (s5_q),
    .rgb_o (rgb_d)
  );

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      rgb_q    <= rgb_d;
      s6_val_q <= s5_q.val;
    end
  end

  assign red_o   = rgb_q.red;
  assign green_o = rgb_q.green;
  assign blue_o  = rgb_q.blue;

  // The reduced hue must stay below a full turn.
  `ASSERT_CLK(a_deg_range, vld_q[2] |-> (s2_deg_q < DegFull), "hue remainder out of range")
  // The region position never exceeds 250.
  `ASSERT_CLK(a_frac_range, vld_q[3] |-> (s3_frac_q <= 8'd250), "position out of range")
  // One channel always carries the full brightness.
  `ASSERT_CLK(a_peak_chan,
    valid_o |-> (red_o == s6_val_q || green_o == s6_val_q || blue_o == s6_val_q),
    "no channel at brightness")
  // An accepted transaction always occupies the first stage.
  `ASSERT_CLK(a_accept_fill, (valid_i && !stall_o) |=> vld_q[1], "accepted pixel lost")

endmodule

`default_nettype wire
